// ----- rtl/spe_pkg.sv -----
// Package: shared constants, codes and types of the swap permutation enumerator.
package spe_pkg;

  localparam int MAX_ELEMENTS = 8;
  localparam int SYMBOL_WIDTH = 8;
  localparam int IDX_W        = $clog2(MAX_ELEMENTS);
  localparam int LVL_W        = $clog2(MAX_ELEMENTS + 1);
  localparam int OP_W         = 2;
  localparam int CFG_W        = 4;
  localparam int APB_DATA_W   = 32;
  localparam int APB_ADDR_W   = 3;

  localparam logic [APB_ADDR_W-1:0] ADDR_ELEMENT_COUNT = 3'd0;
  localparam logic [CFG_W-1:0]      ELEMENT_COUNT_RST  = 4'd8;

  typedef enum logic [OP_W-1:0] {
    OP_LOAD    = 2'd0,
    OP_RESTART = 2'd1,
    OP_NEXT    = 2'd2
  } op_e;

  typedef enum logic [3:0] {
    S_IDLE,
    S_RW,
    S_RW_C,
    S_SW_A,
    S_SW_B,
    S_LOAD,
    S_DESC,
    S_ADV,
    S_ADV_C,
    S_ADV_INC,
    S_EXH,
    S_EM_RD,
    S_EM_WR
  } state_e;

  typedef struct packed {
    logic                    re;
    logic [IDX_W-1:0]        raddr_a;
    logic [IDX_W-1:0]        raddr_b;
    logic                    we;
    logic [IDX_W-1:0]        waddr;
    logic [SYMBOL_WIDTH-1:0] wdata;
  } sym_req_t;

  typedef struct packed {
    logic             re;
    logic [IDX_W-1:0] raddr;
    logic             we;
    logic [IDX_W-1:0] waddr;
    logic [LVL_W-1:0] wdata;
  } lvl_req_t;

endpackage

// ----- rtl/spe_if.sv -----
// Interfaces: input item channel and result channel with valid/ready handshake.
interface spe_in_if;
  logic                             valid;
  logic                             ready;
  logic [spe_pkg::OP_W-1:0]         operation;
  logic [spe_pkg::IDX_W-1:0]        load_index;
  logic [spe_pkg::SYMBOL_WIDTH-1:0] load_symbol;

  modport source (output valid, operation, load_index, load_symbol, input ready);
  modport sink   (input valid, operation, load_index, load_symbol, output ready);
endinterface

interface spe_out_if;
  logic                             valid;
  logic                             ready;
  logic [spe_pkg::SYMBOL_WIDTH-1:0] out_symbol;
  logic [spe_pkg::IDX_W-1:0]        out_position;
  logic                             last_of_permutation;
  logic                             exhausted;

  modport source (output valid, out_symbol, out_position, last_of_permutation, exhausted,
                  input ready);
  modport sink   (input valid, out_symbol, out_position, last_of_permutation, exhausted,
                  output ready);
endinterface

// ----- rtl/spe_symbol_ram.sv -----
// Symbol store: two registered read ports, one write port.
module spe_symbol_ram (
  input  logic                             clk_i,
  input  spe_pkg::sym_req_t                req_i,
  output logic [spe_pkg::SYMBOL_WIDTH-1:0] rd_a_o,
  output logic [spe_pkg::SYMBOL_WIDTH-1:0] rd_b_o
);

  logic [spe_pkg::SYMBOL_WIDTH-1:0] mem [spe_pkg::MAX_ELEMENTS];
  logic [spe_pkg::SYMBOL_WIDTH-1:0] rd_a_q;
  logic [spe_pkg::SYMBOL_WIDTH-1:0] rd_b_q;

  always_ff @(posedge clk_i) begin
    if (req_i.we) begin
      mem[req_i.waddr] <= req_i.wdata;
    end
    // hold read data while no read is issued
    if (req_i.re) begin
      rd_a_q <= mem[req_i.raddr_a];
      rd_b_q <= mem[req_i.raddr_b];
    end
  end

  assign rd_a_o = rd_a_q;
  assign rd_b_o = rd_b_q;

endmodule

// ----- rtl/spe_level_ram.sv -----
// Level counter stack: one registered read port, one write port.
module spe_level_ram (
  input  logic                      clk_i,
  input  spe_pkg::lvl_req_t         req_i,
  output logic [spe_pkg::LVL_W-1:0] rd_o
);

  logic [spe_pkg::LVL_W-1:0] mem [spe_pkg::MAX_ELEMENTS];
  logic [spe_pkg::LVL_W-1:0] rd_q;

  always_ff @(posedge clk_i) begin
    if (req_i.we) begin
      mem[req_i.waddr] <= req_i.wdata;
    end
    if (req_i.re) begin
      rd_q <= mem[req_i.raddr];
    end
  end

  assign rd_o = rd_q;

endmodule

// ----- rtl/spe_cfg.sv -----
// APB register block: element_count register and its restart pulse.
module spe_cfg (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [spe_pkg::APB_ADDR_W-1:0] paddr,
  input  logic [spe_pkg::APB_DATA_W-1:0] pwdata,
  output logic [spe_pkg::APB_DATA_W-1:0] prdata,
  output logic                           pready,
  output logic [spe_pkg::CFG_W-1:0]      element_count_o,
  output logic                           restart_o
);

  logic                         wr_hit;
  logic [spe_pkg::CFG_W-1:0]    element_count_q;
  logic [spe_pkg::CFG_W-1:0]    element_count_d;

  assign pready = 1'b1;
  assign wr_hit = psel && penable && pwrite && (paddr == spe_pkg::ADDR_ELEMENT_COUNT);

  always_comb begin
    element_count_d = element_count_q;
    if (wr_hit) begin
      element_count_d = pwdata[spe_pkg::CFG_W-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      element_count_q <= spe_pkg::ELEMENT_COUNT_RST;
    end else begin
      element_count_q <= element_count_d;
    end
  end

  always_comb begin
    prdata = '0;
    if (paddr == spe_pkg::ADDR_ELEMENT_COUNT) begin
      prdata = spe_pkg::APB_DATA_W'(element_count_q);
    end
  end

  assign element_count_o = element_count_q;
  assign restart_o       = wr_hit;

endmodule

// ----- rtl/spe_sequencer.sv -----
// Sequencer: walks the level stack and symbol store, drives the result register.
module spe_sequencer (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  spe_in_if.sink                    in_i,
  spe_out_if.source                 out_o,
  input  logic [spe_pkg::CFG_W-1:0] element_count_i,
  input  logic                      restart_i,
  output spe_pkg::sym_req_t         sym_req_o,
  input  logic [spe_pkg::SYMBOL_WIDTH-1:0] sym_rd_a_i,
  input  logic [spe_pkg::SYMBOL_WIDTH-1:0] sym_rd_b_i,
  output spe_pkg::lvl_req_t         lvl_req_o,
  input  logic [spe_pkg::LVL_W-1:0] lvl_rd_i
);

  spe_pkg::state_e state_q, state_d;
  spe_pkg::state_e ret_q, ret_d;

  logic [spe_pkg::LVL_W-1:0] lv_q, lv_d;
  logic [spe_pkg::LVL_W-1:0] k_q, k_d;
  logic [spe_pkg::LVL_W-1:0] c_q, c_d;
  logic [spe_pkg::LVL_W-1:0] cur_level_q, cur_level_d;
  logic [spe_pkg::IDX_W-1:0] p_q, p_d;
  logic [spe_pkg::IDX_W-1:0] swa_q, swa_d;
  logic [spe_pkg::IDX_W-1:0] swb_q, swb_d;
  logic                      started_q, started_d;
  logic                      done_q, done_d;
  logic                      load_pend_q, load_pend_d;
  logic [spe_pkg::IDX_W-1:0]        ld_idx_q, ld_idx_d;
  logic [spe_pkg::SYMBOL_WIDTH-1:0] ld_sym_q, ld_sym_d;

  logic                             out_valid_q, out_valid_d;
  logic [spe_pkg::SYMBOL_WIDTH-1:0] out_symbol_q, out_symbol_d;
  logic [spe_pkg::IDX_W-1:0]        out_position_q, out_position_d;
  logic                             out_last_q, out_last_d;
  logic                             out_exh_q, out_exh_d;

  logic [spe_pkg::LVL_W-1:0] n;
  logic [spe_pkg::IDX_W-1:0] last_pos;
  logic [spe_pkg::LVL_W-1:0] cn;
  logic                      accept;
  logic                      out_free;
  spe_pkg::op_e              op;

  // clamp the count to 1..MAX_ELEMENTS
  always_comb begin
    if (element_count_i == '0) begin
      n = spe_pkg::LVL_W'(1);
    end else if (spe_pkg::LVL_W'(element_count_i) > spe_pkg::LVL_W'(spe_pkg::MAX_ELEMENTS)) begin
      n = spe_pkg::LVL_W'(spe_pkg::MAX_ELEMENTS);
    end else begin
      n = spe_pkg::LVL_W'(element_count_i);
    end
  end

  assign last_pos = spe_pkg::IDX_W'(n - 1'b1);
  assign cn       = c_q + 1'b1;
  assign in_i.ready = (state_q == spe_pkg::S_IDLE) && !restart_i;
  assign accept   = in_i.valid && in_i.ready;
  assign out_free = !out_valid_q || out_o.ready;
  assign op       = spe_pkg::op_e'(in_i.operation);

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      spe_pkg::S_IDLE: begin
        if (restart_i) begin
          state_d = spe_pkg::S_RW;
        end else if (accept) begin
          unique case (op)
            spe_pkg::OP_LOAD, spe_pkg::OP_RESTART: state_d = spe_pkg::S_RW;
            spe_pkg::OP_NEXT: begin
              if (done_q)         state_d = spe_pkg::S_EXH;
              else if (started_q) state_d = spe_pkg::S_ADV;
              else                state_d = spe_pkg::S_DESC;
            end
            default: state_d = spe_pkg::S_IDLE;
          endcase
        end
      end
      spe_pkg::S_RW: begin
        if (lv_q != '0)       state_d = spe_pkg::S_RW_C;
        else if (load_pend_q) state_d = spe_pkg::S_LOAD;
        else                  state_d = spe_pkg::S_IDLE;
      end
      spe_pkg::S_RW_C:  state_d = spe_pkg::S_SW_A;
      spe_pkg::S_SW_A:  state_d = spe_pkg::S_SW_B;
      spe_pkg::S_SW_B:  state_d = ret_q;
      spe_pkg::S_LOAD:  state_d = spe_pkg::S_IDLE;
      spe_pkg::S_DESC:  state_d = (k_q < n) ? spe_pkg::S_DESC : spe_pkg::S_EM_RD;
      spe_pkg::S_ADV:   state_d = (lv_q == '0) ? spe_pkg::S_EXH : spe_pkg::S_ADV_C;
      spe_pkg::S_ADV_C: state_d = spe_pkg::S_SW_A;
      spe_pkg::S_ADV_INC: state_d = (cn < n) ? spe_pkg::S_SW_A : spe_pkg::S_ADV;
      spe_pkg::S_EXH:   state_d = out_free ? spe_pkg::S_IDLE : spe_pkg::S_EXH;
      spe_pkg::S_EM_RD: state_d = spe_pkg::S_EM_WR;
      spe_pkg::S_EM_WR: begin
        if (out_free) begin
          state_d = (p_q == last_pos) ? spe_pkg::S_IDLE : spe_pkg::S_EM_RD;
        end
      end
      default: state_d = spe_pkg::S_IDLE;
    endcase
  end

  // memory requests and datapath
  always_comb begin
    ret_d          = ret_q;
    lv_d           = lv_q;
    k_d            = k_q;
    c_d            = c_q;
    cur_level_d    = cur_level_q;
    p_d            = p_q;
    swa_d          = swa_q;
    swb_d          = swb_q;
    started_d      = started_q;
    done_d         = done_q;
    load_pend_d    = load_pend_q;
    ld_idx_d       = ld_idx_q;
    ld_sym_d       = ld_sym_q;
    out_valid_d    = out_valid_q && !out_o.ready;
    out_symbol_d   = out_symbol_q;
    out_position_d = out_position_q;
    out_last_d     = out_last_q;
    out_exh_d      = out_exh_q;
    sym_req_o      = '0;
    lvl_req_o      = '0;

    unique case (state_q)
      spe_pkg::S_IDLE: begin
        if (restart_i) begin
          lv_d        = cur_level_q;
          load_pend_d = 1'b0;
        end else if (accept) begin
          unique case (op)
            spe_pkg::OP_LOAD: begin
              lv_d        = cur_level_q;
              load_pend_d = 1'b1;
              ld_idx_d    = in_i.load_index;
              ld_sym_d    = in_i.load_symbol;
            end
            spe_pkg::OP_RESTART: begin
              lv_d        = cur_level_q;
              load_pend_d = 1'b0;
            end
            spe_pkg::OP_NEXT: begin
              lv_d = cur_level_q;
              k_d  = '0;
            end
            default: begin
              lv_d = lv_q;
            end
          endcase
        end
      end
      // undo the swaps still in effect, deepest level first
      spe_pkg::S_RW: begin
        if (lv_q == '0) begin
          cur_level_d = '0;
          started_d   = 1'b0;
          done_d      = 1'b0;
        end else begin
          lv_d            = lv_q - 1'b1;
          lvl_req_o.re    = 1'b1;
          lvl_req_o.raddr = spe_pkg::IDX_W'(lv_q - 1'b1);
        end
      end
      spe_pkg::S_RW_C: begin
        swa_d             = spe_pkg::IDX_W'(lv_q);
        swb_d             = spe_pkg::IDX_W'(lvl_rd_i);
        sym_req_o.re      = 1'b1;
        sym_req_o.raddr_a = spe_pkg::IDX_W'(lv_q);
        sym_req_o.raddr_b = spe_pkg::IDX_W'(lvl_rd_i);
        ret_d             = spe_pkg::S_RW;
      end
      spe_pkg::S_SW_A: begin
        sym_req_o.we    = 1'b1;
        sym_req_o.waddr = swa_q;
        sym_req_o.wdata = sym_rd_b_i;
      end
      spe_pkg::S_SW_B: begin
        sym_req_o.we    = 1'b1;
        sym_req_o.waddr = swb_q;
        sym_req_o.wdata = sym_rd_a_i;
      end
      spe_pkg::S_LOAD: begin
        sym_req_o.we    = 1'b1;
        sym_req_o.waddr = ld_idx_q;
        sym_req_o.wdata = ld_sym_q;
        load_pend_d     = 1'b0;
      end
      // first choice at each deeper level is the level itself
      spe_pkg::S_DESC: begin
        if (k_q < n) begin
          lvl_req_o.we    = 1'b1;
          lvl_req_o.waddr = spe_pkg::IDX_W'(k_q);
          lvl_req_o.wdata = k_q;
          k_d             = k_q + 1'b1;
        end else begin
          cur_level_d = n;
          started_d   = 1'b1;
          p_d         = '0;
        end
      end
      spe_pkg::S_ADV: begin
        if (lv_q == '0) begin
          cur_level_d = '0;
          done_d      = 1'b1;
        end else begin
          lv_d            = lv_q - 1'b1;
          lvl_req_o.re    = 1'b1;
          lvl_req_o.raddr = spe_pkg::IDX_W'(lv_q - 1'b1);
        end
      end
      // swap back the current choice of this level
      spe_pkg::S_ADV_C: begin
        c_d               = lvl_rd_i;
        swa_d             = spe_pkg::IDX_W'(lv_q);
        swb_d             = spe_pkg::IDX_W'(lvl_rd_i);
        sym_req_o.re      = 1'b1;
        sym_req_o.raddr_a = spe_pkg::IDX_W'(lv_q);
        sym_req_o.raddr_b = spe_pkg::IDX_W'(lvl_rd_i);
        ret_d             = spe_pkg::S_ADV_INC;
      end
      // bump the choice; if one is left, swap it in and descend
      spe_pkg::S_ADV_INC: begin
        lvl_req_o.we    = 1'b1;
        lvl_req_o.waddr = spe_pkg::IDX_W'(lv_q);
        lvl_req_o.wdata = cn;
        if (cn < n) begin
          swa_d             = spe_pkg::IDX_W'(lv_q);
          swb_d             = spe_pkg::IDX_W'(cn);
          sym_req_o.re      = 1'b1;
          sym_req_o.raddr_a = spe_pkg::IDX_W'(lv_q);
          sym_req_o.raddr_b = spe_pkg::IDX_W'(cn);
          k_d               = lv_q + 1'b1;
          ret_d             = spe_pkg::S_DESC;
        end
      end
      spe_pkg::S_EXH: begin
        if (out_free) begin
          out_valid_d    = 1'b1;
          out_symbol_d   = '0;
          out_position_d = '0;
          out_last_d     = 1'b1;
          out_exh_d      = 1'b1;
        end
      end
      spe_pkg::S_EM_RD: begin
        sym_req_o.re      = 1'b1;
        sym_req_o.raddr_a = p_q;
      end
      spe_pkg::S_EM_WR: begin
        if (out_free) begin
          out_valid_d    = 1'b1;
          out_symbol_d   = sym_rd_a_i;
          out_position_d = p_q;
          out_last_d     = (p_q == last_pos);
          out_exh_d      = 1'b0;
          p_d            = p_q + 1'b1;
        end
      end
      default: begin
        lv_d = lv_q;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= spe_pkg::S_IDLE;
      ret_q       <= spe_pkg::S_IDLE;
      cur_level_q <= '0;
      started_q   <= 1'b0;
      done_q      <= 1'b0;
      load_pend_q <= 1'b0;
      out_valid_q <= 1'b0;
      lv_q        <= '0;
      k_q         <= '0;
      p_q         <= '0;
    end else begin
      state_q     <= state_d;
      ret_q       <= ret_d;
      cur_level_q <= cur_level_d;
      started_q   <= started_d;
      done_q      <= done_d;
      load_pend_q <= load_pend_d;
      out_valid_q <= out_valid_d;
      lv_q        <= lv_d;
      k_q         <= k_d;
      p_q         <= p_d;
    end
  end

  always_ff @(posedge clk_i) begin
    c_q            <= c_d;
    swa_q          <= swa_d;
    swb_q          <= swb_d;
    ld_idx_q       <= ld_idx_d;
    ld_sym_q       <= ld_sym_d;
    out_symbol_q   <= out_symbol_d;
    out_position_q <= out_position_d;
    out_last_q     <= out_last_d;
    out_exh_q      <= out_exh_d;
  end

  assign out_o.valid               = out_valid_q;
  assign out_o.out_symbol          = out_symbol_q;
  assign out_o.out_position        = out_position_q;
  assign out_o.last_of_permutation = out_last_q;
  assign out_o.exhausted           = out_exh_q;

endmodule

// ----- rtl/swap_permutation_enumerator_core.sv -----
// Top level: swap permutation enumerator with APB configuration.
//
// Usage: load symbols with operation LOAD (index, symbol), set element_count over
// APB (register 0, byte address 0), then send NEXT items. Each NEXT returns the
// current ordering as n transfers on out_o (n = element_count clamped to 1..8),
// position 0 first, the last one flagged; once every ordering was sent, NEXT
// returns one exhausted transfer. RESTART, LOAD and an element_count write
// rewind the enumeration. One item is worked at a time; in_i.ready is high only
// while the sequencer idles. The pace of an item is set by the one write port of
// the symbol store (a swap reads both symbols, then writes each back in turn)
// and the one read per emitted symbol: RESTART and LOAD undo every swap in effect,
// deepest level first, and a NEXT descends or backtracks, then emits its symbols.
// A stalled receiver holds the result register and the sequencer waits in place;
// the next item is taken while the final result still waits. Reset clears the
// control state and sets element_count to 8; the symbol store holds nothing
// defined until loaded, and level counters need no clearing because each is
// written on descent before it is read.
module swap_permutation_enumerator_core (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  spe_in_if.sink                         in_i,
  spe_out_if.source                      out_o,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [spe_pkg::APB_ADDR_W-1:0] paddr,
  input  logic [spe_pkg::APB_DATA_W-1:0] pwdata,
  output logic [spe_pkg::APB_DATA_W-1:0] prdata,
  output logic                           pready
);

  logic [spe_pkg::CFG_W-1:0]        element_count;
  logic                             restart;
  spe_pkg::sym_req_t                sym_req;
  spe_pkg::lvl_req_t                lvl_req;
  logic [spe_pkg::SYMBOL_WIDTH-1:0] sym_rd_a;
  logic [spe_pkg::SYMBOL_WIDTH-1:0] sym_rd_b;
  logic [spe_pkg::LVL_W-1:0]        lvl_rd;

  // register port; a write to element_count also rewinds
  spe_cfg u_cfg (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .psel            (psel),
    .penable         (penable),
    .pwrite          (pwrite),
    .paddr           (paddr),
    .pwdata          (pwdata),
    .prdata          (prdata),
    .pready          (pready),
    .element_count_o (element_count),
    .restart_o       (restart)
  );

  // symbols, permuted in place by swaps
  spe_symbol_ram u_sym_ram (
    .clk_i  (clk_i),
    .req_i  (sym_req),
    .rd_a_o (sym_rd_a),
    .rd_b_o (sym_rd_b)
  );

  // one loop counter per recursion level
  spe_level_ram u_lvl_ram (
    .clk_i (clk_i),
    .req_i (lvl_req),
    .rd_o  (lvl_rd)
  );

  // read-modify-write sequencing is strictly ordered, so no access overlaps
  spe_sequencer u_seq (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_i            (in_i),
    .out_o           (out_o),
    .element_count_i (element_count),
    .restart_i       (restart),
    .sym_req_o       (sym_req),
    .sym_rd_a_i      (sym_rd_a),
    .sym_rd_b_i      (sym_rd_b),
    .lvl_req_o       (lvl_req),
    .lvl_rd_i        (lvl_rd)
  );

endmodule

// ----- tb/perm_order_checker.sv -----
// Checker: predicts each ordering the enumerator must emit and scores every result transfer.
module perm_order_checker
  import spe_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  spe_in_if                     in_mon,
  spe_out_if                    out_mon,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic                  pready,
  input  logic [APB_ADDR_W-1:0] paddr,
  input  logic [APB_DATA_W-1:0] pwdata,
  output int                    err_count,
  output int                    pending,
  output int                    results_seen,
  output int                    orderings_seen,
  output int                    exhausted_seen
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [SYMBOL_WIDTH-1:0] symbol;
    logic [IDX_W-1:0]        position;
    logic                    last_flag;
    logic                    exh_flag;
  } result_t;

  // Shadow of the enumerator: symbols permuted in place, one loop counter per level.
  logic [SYMBOL_WIDTH-1:0] sym_q [MAX_ELEMENTS];
  logic [LVL_W-1:0]        cnt_at [MAX_ELEMENTS];
  int unsigned             depth;
  bit                      started;
  bit                      finished;
  logic [CFG_W-1:0]        count_reg;
  result_t                 symbols_due [$];

  function automatic int unsigned span();
    int unsigned n;
    n = count_reg;
    if (n < 1) n = 1;
    if (n > MAX_ELEMENTS) n = MAX_ELEMENTS;
    return n;
  endfunction

  function automatic void swap_syms(int unsigned a, int unsigned b);
    logic [SYMBOL_WIDTH-1:0] tmp;
    if (a >= MAX_ELEMENTS || b >= MAX_ELEMENTS) return;
    tmp = sym_q[a];
    sym_q[a] = sym_q[b];
    sym_q[b] = tmp;
  endfunction

  // Enter levels from..n-1, each taking its first choice (a swap with itself).
  function automatic void go_down(int unsigned from, int unsigned n);
    for (int unsigned lv = from; lv < n; lv++) cnt_at[lv] = LVL_W'(lv);
    depth = n;
  endfunction

  // Backtrack to the deepest level with a choice left and descend again.
  function automatic bit step_forward(int unsigned n);
    int unsigned lv;
    lv = (depth > n) ? n : depth;
    while (lv > 0) begin
      lv--;
      swap_syms(lv, cnt_at[lv]);
      cnt_at[lv] = cnt_at[lv] + 1'b1;
      if (cnt_at[lv] < n) begin
        swap_syms(lv, cnt_at[lv]);
        go_down(lv + 1, n);
        return 1'b1;
      end
    end
    depth = 0;
    return 1'b0;
  endfunction

  // Undo every swap still in effect, restoring the loaded order.
  function automatic void rewind_swaps();
    int unsigned lv;
    lv = (depth > MAX_ELEMENTS) ? MAX_ELEMENTS : depth;
    while (lv > 0) begin
      lv--;
      swap_syms(lv, cnt_at[lv]);
    end
    foreach (cnt_at[k]) cnt_at[k] = '0;
    depth    = 0;
    started  = 1'b0;
    finished = 1'b0;
  endfunction

  function automatic void push_ordering(int unsigned n);
    for (int unsigned p = 0; p < n; p++)
      symbols_due.push_back(result_t'{symbol: sym_q[p], position: IDX_W'(p),
                                      last_flag: (p == n - 1), exh_flag: 1'b0});
  endfunction

  function automatic void push_exhausted();
    symbols_due.push_back(result_t'{symbol: '0, position: '0, last_flag: 1'b1,
                                    exh_flag: 1'b1});
  endfunction

  function automatic void predict_item(logic [OP_W-1:0] op, logic [IDX_W-1:0] idx,
                                       logic [SYMBOL_WIDTH-1:0] sym);
    int unsigned n;
    n = span();
    case (op)
      OP_LOAD: begin
        rewind_swaps();
        sym_q[idx] = sym;
      end
      OP_RESTART: rewind_swaps();
      OP_NEXT: begin
        if (finished) begin
          push_exhausted();
        end else if (!started) begin
          go_down(0, n);
          started = 1'b1;
          push_ordering(n);
        end else if (step_forward(n)) begin
          push_ordering(n);
        end else begin
          finished = 1'b1;
          push_exhausted();
        end
      end
      default: ;
    endcase
  endfunction

  // Fields are shown as symbol/position/last/exhausted.
  function automatic void score_result();
    result_t got;
    result_t want;
    got = {out_mon.out_symbol, out_mon.out_position, out_mon.last_of_permutation,
           out_mon.exhausted};
    results_seen++;
    if (got.exh_flag) exhausted_seen++;
    else if (got.last_flag) orderings_seen++;
    if (symbols_due.size() == 0) begin
      err_count++;
      $display("%0t: unexpected result: expected none, got %02h/%0d/%b/%b", $time,
               got.symbol, got.position, got.last_flag, got.exh_flag);
      return;
    end
    want = symbols_due.pop_front();
    if (got.symbol !== want.symbol || got.position !== want.position ||
        got.last_flag !== want.last_flag || got.exh_flag !== want.exh_flag) begin
      err_count++;
      $display("%0t: mismatch: expected %02h/%0d/%b/%b, got %02h/%0d/%b/%b",
               $time, want.symbol, want.position, want.last_flag, want.exh_flag,
               got.symbol, got.position, got.last_flag, got.exh_flag);
    end
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      foreach (sym_q[k]) sym_q[k] = '0;
      rewind_swaps();
      count_reg = ELEMENT_COUNT_RST;
      symbols_due.delete();
    end else begin
      if (out_mon.valid && out_mon.ready) score_result();
      if (psel && penable && pwrite && pready && paddr == ADDR_ELEMENT_COUNT) begin
        rewind_swaps();
        count_reg = pwdata[CFG_W-1:0];
      end
      if (in_mon.valid && in_mon.ready)
        predict_item(in_mon.operation, in_mon.load_index, in_mon.load_symbol);
    end
    pending = symbols_due.size();
  end

endmodule

// ----- tb/tb.sv -----
// Testbench top: drives items and register writes into the enumerator, gives the verdict.
module tb;
  import spe_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int                    RANDOM_ITEMS = 245;
  localparam int                    DRAIN_GAP    = 40;     // outlasts the longest rewind
  localparam int                    HOLD_CYCLES  = 300;
  localparam int                    CYCLE_LIMIT  = 400000;
  localparam logic [OP_W-1:0]       OP_UNUSED    = 2'd3;
  localparam logic [APB_ADDR_W-1:0] ADDR_UNUSED  = 3'd4;  // register index 1 is not decoded

  logic                  clk_i;
  logic                  rst_ni;
  logic                  psel;
  logic                  penable;
  logic                  pwrite;
  logic [APB_ADDR_W-1:0] paddr;
  logic [APB_DATA_W-1:0] pwdata;
  logic [APB_DATA_W-1:0] prdata;
  logic                  pready;

  spe_in_if  in_bus ();
  spe_out_if out_bus ();

  int err_count;
  int pending;
  int results_seen;
  int orderings_seen;
  int exhausted_seen;

  int src_idle_pct   = 0;
  int sink_stall_pct = 0;
  bit hold_start     = 1'b0;
  int cycle_count    = 0;
  int items_sent     = 0;
  int settings_used  = 0;

  swap_permutation_enumerator_core dut (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .in_i    (in_bus),
    .out_o   (out_bus),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  perm_order_checker checker_i (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_mon         (in_bus),
    .out_mon        (out_bus),
    .psel           (psel),
    .penable        (penable),
    .pwrite         (pwrite),
    .pready         (pready),
    .paddr          (paddr),
    .pwdata         (pwdata),
    .err_count      (err_count),
    .pending        (pending),
    .results_seen   (results_seen),
    .orderings_seen (orderings_seen),
    .exhausted_seen (exhausted_seen)
  );

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  // Hard stop in case the block hangs or a result never arrives.
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  // Result receiver: stall at the phase rate, or hold off for a long stretch on request
  // so the block backs up and stops taking items.
  initial begin
    int hold_left;
    hold_left = 0;
    out_bus.ready <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (hold_start) begin
        hold_start = 1'b0;
        hold_left  = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_bus.ready <= 1'b0;
      end else begin
        out_bus.ready <= ($urandom_range(99) >= sink_stall_pct);
      end
    end
  end

  // Offer one item, idling first at the phase rate; return at the edge of the transfer
  // with valid still high, so back-to-back items keep it asserted.
  task automatic offer(input logic [OP_W-1:0] op, input logic [IDX_W-1:0] idx,
                       input logic [SYMBOL_WIDTH-1:0] sym);
    while ($urandom_range(99) < src_idle_pct) begin
      in_bus.valid <= 1'b0;
      @(posedge clk_i);
    end
    in_bus.valid       <= 1'b1;
    in_bus.operation   <= op;
    in_bus.load_index  <= idx;
    in_bus.load_symbol <= sym;
    @(posedge clk_i);
    while (!in_bus.ready) @(posedge clk_i);
    if (op != OP_UNUSED) items_sent++;
  endtask

  // Mostly NEXT, with restarts, reloads and the odd unused code mixed in.
  task automatic offer_mixed();
    int pick;
    pick = $urandom_range(99);
    if (pick < 80)
      offer(OP_NEXT, IDX_W'($urandom_range(7)), SYMBOL_WIDTH'($urandom_range(255)));
    else if (pick < 88)
      offer(OP_RESTART, IDX_W'($urandom_range(7)), SYMBOL_WIDTH'($urandom_range(255)));
    else if (pick < 96)
      offer(OP_LOAD, IDX_W'($urandom_range(7)), SYMBOL_WIDTH'($urandom_range(255)));
    else
      offer(OP_UNUSED, IDX_W'($urandom_range(7)), SYMBOL_WIDTH'($urandom_range(255)));
  endtask

  // Drop valid, let every expected result drain, then give a rewind time to finish.
  task automatic wait_idle();
    in_bus.valid <= 1'b0;
    do @(negedge clk_i); while (pending != 0);
    repeat (DRAIN_GAP) @(posedge clk_i);
  endtask

  // Register write: setup cycle, then access cycle until pready.
  task automatic write_reg(input logic [APB_ADDR_W-1:0] addr, input logic [CFG_W-1:0] value);
    logic [APB_DATA_W-1:0] word;
    word = $urandom();
    word[CFG_W-1:0] = value;
    wait_idle();
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= word;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    if (addr == ADDR_ELEMENT_COUNT) settings_used++;
  endtask

  initial begin
    logic [SYMBOL_WIDTH-1:0] seed_syms [MAX_ELEMENTS];
    int                      count_plan [12];
    logic [CFG_W-1:0]        cnt;
    int                      n;
    int                      run;
    int                      ph;
    int                      goal;

    seed_syms  = '{8'h00, 8'hFF, 8'hA5, 8'h5A, 8'h3C, 8'hC3, 8'h01, 8'h80};
    count_plan = '{3, 8, 1, 4, 15, 2, 0, 5, 4, 6, 3, 8};

    rst_ni              = 1'b0;
    in_bus.valid       <= 1'b0;
    in_bus.operation   <= OP_LOAD;
    in_bus.load_index  <= '0;
    in_bus.load_symbol <= '0;
    psel               <= 1'b0;
    penable            <= 1'b0;
    pwrite             <= 1'b0;
    paddr              <= '0;
    pwdata             <= '0;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Load every position first, so no emitted position is ever unwritten.
    for (int k = 0; k < MAX_ELEMENTS; k++) offer(OP_LOAD, IDX_W'(k), seed_syms[k]);

    // Reset count of 8: first ordering, then advance.
    offer(OP_NEXT, '0, '0);
    offer(OP_NEXT, '1, '1);
    // A write to an undecoded register must not rewind.
    write_reg(ADDR_UNUSED, 4'd5);
    offer(OP_NEXT, '0, '0);
    // Restart rewinds to the loaded order; the unused code is dropped.
    offer(OP_RESTART, '0, '0);
    offer(OP_NEXT, '0, '0);
    offer(OP_UNUSED, '1, '1);
    // Load in the middle of an enumeration rewinds before writing.
    offer(OP_NEXT, '0, '0);
    offer(OP_LOAD, IDX_W'(2), 8'h7E);
    offer(OP_NEXT, '0, '0);

    // Single symbol: one ordering, then repeated exhausted answers.
    write_reg(ADDR_ELEMENT_COUNT, 4'd1);
    repeat (3) offer(OP_NEXT, '0, '0);
    // Count of zero acts as one.
    write_reg(ADDR_ELEMENT_COUNT, 4'd0);
    repeat (2) offer(OP_NEXT, '0, '0);
    // Count above the maximum acts as the maximum.
    write_reg(ADDR_ELEMENT_COUNT, 4'd15);
    repeat (2) offer(OP_NEXT, '0, '0);
    // Two symbols: both orderings, then exhausted.
    write_reg(ADDR_ELEMENT_COUNT, 4'd2);
    repeat (3) offer(OP_NEXT, '0, '0);

    // Random phases: each sets a count and an idling mode; small counts first run a clean
    // enumeration to exhaustion, then a random mix follows.
    goal = items_sent + RANDOM_ITEMS;
    ph   = 0;
    while (items_sent < goal) begin
      cnt = (ph < 12) ? CFG_W'(count_plan[ph]) : CFG_W'($urandom_range(15));
      case (ph % 4)
        0: begin
          src_idle_pct   = 0;
          sink_stall_pct = 0;
        end
        1: begin
          src_idle_pct   = 58;
          sink_stall_pct = 0;
        end
        2: begin
          src_idle_pct   = 0;
          sink_stall_pct = 58;
        end
        default: begin
          src_idle_pct   = 33;
          sink_stall_pct = 33;
        end
      endcase
      write_reg(ADDR_ELEMENT_COUNT, cnt);
      // Hold off the receiver while a busy sender keeps offering full-width NEXTs.
      if (ph == 4) hold_start = 1'b1;
      n = (cnt == 0) ? 1 : ((cnt > MAX_ELEMENTS) ? MAX_ELEMENTS : int'(cnt));
      if (n <= 4) begin
        run = 1;
        for (int k = 2; k <= n; k++) run *= k;
        repeat (run + 2)
          offer(OP_NEXT, IDX_W'($urandom_range(7)), SYMBOL_WIDTH'($urandom_range(255)));
      end
      repeat (16) offer_mixed();
      ph++;
    end

    wait_idle();
    $display("Run covered %0d items over %0d count settings (counts 0 to 15, mixed pacing).",
             items_sent, settings_used);
    $display("Checked %0d results: %0d full orderings and %0d exhausted answers.",
             results_seen, orderings_seen, exhausted_seen);
    if (err_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
